>>> src/ftqg_pkg.sv
package ftqg_pkg;

  // Field widths
  localparam int unsigned FRAME_W    = 20;
  localparam int unsigned TH_W       = 3;
  localparam int unsigned SCALE_W    = 10;
  localparam int unsigned LEVEL_W    = 3;
  localparam int unsigned STEP_W     = 8;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned EMA_W      = 28;
  localparam int unsigned EMA_FRAC   = 8;
  localparam int unsigned GAIN_W     = 12;
  localparam int unsigned MUL_W      = EMA_W + GAIN_W;
  localparam int unsigned PROD_W     = 27;
  localparam int unsigned DROP_W     = 22;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 56;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_BUDGET    = 3'd0,
    CFG_MIN_SCALE       = 3'd1,
    CFG_MAX_SCALE       = 3'd2,
    CFG_SCALE_STEP      = 3'd3,
    CFG_DOWN_FRAMES     = 3'd4,
    CFG_UP_FRAMES       = 3'd5,
    CFG_COOLDOWN_FRAMES = 3'd6,
    CFG_QUALITY_CEILING = 3'd7
  } cfg_index_e;

  // Thermal status codes
  localparam logic [TH_W-1:0] TH_NONE      = 3'd0;
  localparam logic [TH_W-1:0] TH_LIGHT     = 3'd1;
  localparam logic [TH_W-1:0] TH_MODERATE  = 3'd2;
  localparam logic [TH_W-1:0] TH_SEVERE    = 3'd3;
  localparam logic [TH_W-1:0] TH_CRITICAL  = 3'd4;
  localparam logic [TH_W-1:0] TH_SHUTDOWN  = 3'd6;

  // Frame time saturation and scale limits
  localparam logic [FRAME_W-1:0] FRAME_MIN     = 20'd100;
  localparam logic [FRAME_W-1:0] FRAME_MAX     = 20'd1000000;
  localparam logic [SCALE_W-1:0] SCALE_LIMIT   = 10'd1000;
  localparam logic [SCALE_W-1:0] SCALE_FLOOR   = 10'd200;
  localparam logic [STEP_W-1:0]  STEP_MIN      = 8'd10;
  localparam logic [STEP_W-1:0]  STEP_MAX      = 8'd250;
  localparam logic [SCALE_W-1:0] CAP_MODERATE  = 10'd850;
  localparam logic [SCALE_W-1:0] CAP_SEVERE    = 10'd650;
  localparam logic [SCALE_W-1:0] CAP_CRITICAL  = 10'd500;
  localparam logic [SCALE_W-1:0] CAP_EMERGENCY = 10'd400;

  // Hysteresis band in percent of budget
  localparam logic [PROD_W-1:0] PCT_SCALE = 27'd100;
  localparam logic [PROD_W-1:0] BAD_PCT   = 27'd110;
  localparam logic [PROD_W-1:0] GOOD_PCT  = 27'd92;

  // Average gain 0.15 as 2458/16384, rounded
  localparam logic [MUL_W-1:0] EMA_GAIN  = 40'd2458;
  localparam logic [MUL_W-1:0] EMA_ROUND = 40'd8192;
  localparam int unsigned      EMA_SHIFT = 14;

  // Register reset values
  localparam logic [FRAME_W-1:0] RST_BUDGET    = 20'd16667;
  localparam logic [SCALE_W-1:0] RST_MIN_SCALE = 10'd400;
  localparam logic [SCALE_W-1:0] RST_MAX_SCALE = 10'd1000;
  localparam logic [STEP_W-1:0]  RST_STEP      = 8'd50;
  localparam logic [COUNT_W-1:0] RST_DOWN      = 16'd6;
  localparam logic [COUNT_W-1:0] RST_UP        = 16'd120;
  localparam logic [COUNT_W-1:0] RST_COOLDOWN  = 16'd30;
  localparam logic [LEVEL_W-1:0] RST_CEILING   = 3'd3;

  // Sanitised limits handed from the register file to the datapath
  typedef struct packed {
    logic [DROP_W-1:0]  budget_x3;
    logic [PROD_W-1:0]  budget_bad;
    logic [PROD_W-1:0]  budget_good;
    logic [SCALE_W-1:0] scale_max;
    logic [SCALE_W-1:0] scale_min;
    logic [STEP_W-1:0]  step;
    logic [COUNT_W-1:0] down;
    logic [COUNT_W-1:0] up;
    logic [COUNT_W-1:0] cooldown;
    logic [LEVEL_W-1:0] ceiling;
  } limits_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_us;
    logic [TH_W-1:0]    thermal_status;
    logic [SCALE_W-1:0] lock_scale;
  } item_t;

  typedef struct packed {
    logic [SCALE_W-1:0] render_scale;
    logic [LEVEL_W-1:0] quality_level;
    logic               dropped;
    logic               lowered;
    logic               raised;
    logic [FRAME_W-1:0] smoothed_frame_us;
    logic [FRAME_W-1:0] worst_frame_us;
  } result_t;

  // Clamp raw registers and precompute budget products (ceiling already limited)
  function automatic limits_t derive_limits(
    input logic [FRAME_W-1:0] budget,
    input logic [SCALE_W-1:0] min_s,
    input logic [SCALE_W-1:0] max_s,
    input logic [STEP_W-1:0]  step,
    input logic [COUNT_W-1:0] dn,
    input logic [COUNT_W-1:0] up,
    input logic [COUNT_W-1:0] cool,
    input logic [LEVEL_W-1:0] ceil
  );
    limits_t            l;
    logic [SCALE_W-1:0] mx;
    logic [SCALE_W-1:0] lo;
    l = '0;
    l.budget_x3   = DROP_W'({budget, 1'b0}) + DROP_W'(budget);
    l.budget_bad  = PROD_W'(budget) * BAD_PCT;
    l.budget_good = PROD_W'(budget) * GOOD_PCT;
    mx = (max_s > SCALE_LIMIT) ? SCALE_LIMIT : max_s;
    lo = (min_s < SCALE_FLOOR) ? SCALE_FLOOR : min_s;
    l.scale_max = mx;
    l.scale_min = (lo > mx) ? mx : lo;
    if (step < STEP_MIN) begin
      l.step = STEP_MIN;
    end else if (step > STEP_MAX) begin
      l.step = STEP_MAX;
    end else begin
      l.step = step;
    end
    l.down     = (dn == '0) ? COUNT_W'(1) : dn;
    l.up       = (up == '0) ? COUNT_W'(1) : up;
    l.cooldown = cool;
    l.ceiling  = ceil;
    return l;
  endfunction

endpackage

>>> src/ftqg_cfg.sv
module ftqg_cfg import ftqg_pkg::*; #(
  parameter int unsigned MAX_LEVELS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output limits_t               limits_o
);

  localparam logic [4:0] LEVEL_TOP = 5'(MAX_LEVELS - 1);
  localparam logic [LEVEL_W-1:0] CEIL_RST =
    ({2'b00, RST_CEILING} > LEVEL_TOP) ? LEVEL_W'(LEVEL_TOP) : RST_CEILING;

  logic [FRAME_W-1:0] budget_q;
  logic [SCALE_W-1:0] min_scale_q, max_scale_q;
  logic [STEP_W-1:0]  step_q;
  logic [COUNT_W-1:0] down_q, up_q, cool_q;
  logic [LEVEL_W-1:0] ceil_q;
  logic [LEVEL_W-1:0] ceil_lim;
  limits_t            limits_d, limits_q;

  assign cfg_ready_o = 1'b1;

  // Raw register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q    <= RST_BUDGET;
      min_scale_q <= RST_MIN_SCALE;
      max_scale_q <= RST_MAX_SCALE;
      step_q      <= RST_STEP;
      down_q      <= RST_DOWN;
      up_q        <= RST_UP;
      cool_q      <= RST_COOLDOWN;
      ceil_q      <= RST_CEILING;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_FRAME_BUDGET:    budget_q    <= cfg_data_i;
        CFG_MIN_SCALE:       min_scale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_MAX_SCALE:       max_scale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_SCALE_STEP:      step_q      <= cfg_data_i[STEP_W-1:0];
        CFG_DOWN_FRAMES:     down_q      <= cfg_data_i[COUNT_W-1:0];
        CFG_UP_FRAMES:       up_q        <= cfg_data_i[COUNT_W-1:0];
        CFG_COOLDOWN_FRAMES: cool_q      <= cfg_data_i[COUNT_W-1:0];
        CFG_QUALITY_CEILING: ceil_q      <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sanitised limits, registered so the budget products stay off the datapath
  always_comb begin
    ceil_lim = ({2'b00, ceil_q} > LEVEL_TOP) ? LEVEL_W'(LEVEL_TOP) : ceil_q;
    limits_d = derive_limits(budget_q, min_scale_q, max_scale_q, step_q,
                             down_q, up_q, cool_q, ceil_lim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q <= derive_limits(RST_BUDGET, RST_MIN_SCALE, RST_MAX_SCALE,
                                RST_STEP, RST_DOWN, RST_UP, RST_COOLDOWN, CEIL_RST);
    end else begin
      limits_q <= limits_d;
    end
  end

  assign limits_o = limits_q;

endmodule

>>> src/ftqg_core.sv
module ftqg_core import ftqg_pkg::*; #(
  parameter int unsigned MAX_LEVELS = 8,
  parameter int unsigned RUN_BITS   = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  limits_t limits_i,
  output result_t result_o
);

  localparam int unsigned CMP_W = (RUN_BITS > COUNT_W) ? RUN_BITS : COUNT_W;
  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};
  localparam logic [4:0] LEVEL_TOP = 5'(MAX_LEVELS - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_RST =
    ({2'b00, RST_CEILING} > LEVEL_TOP) ? LEVEL_W'(LEVEL_TOP) : RST_CEILING;

  // Governor state
  logic [SCALE_W-1:0]  scale_q, scale_d;
  logic [LEVEL_W-1:0]  level_q, level_d;
  logic [RUN_BITS-1:0] bad_q, bad_d, good_q, good_d;
  logic [COUNT_W-1:0]  hold_q, hold_d;
  logic [EMA_W-1:0]    ema_q, ema_d;
  logic [FRAME_W-1:0]  worst_q, worst_d;
  logic                seen_q;

  // Per-item intermediates
  logic [FRAME_W-1:0]  f;
  logic [TH_W-1:0]     th;
  logic [EMA_W-1:0]    target, diff, delta;
  logic [MUL_W-1:0]    prod;
  logic [PROD_W-1:0]   f100;
  logic                is_bad, is_good, dropped, lowered, raised;
  logic [RUN_BITS-1:0] bad1, good1;
  logic [COUNT_W-1:0]  hold1;
  logic [SCALE_W-1:0]  cap_s, fixed;
  logic [LEVEL_W-1:0]  cap_q;
  logic [SCALE_W:0]    sum_dn, sum_up;

  // Saturate inputs and update average and worst frame
  always_comb begin
    if (item_i.frame_us < FRAME_MIN) begin
      f = FRAME_MIN;
    end else if (item_i.frame_us > FRAME_MAX) begin
      f = FRAME_MAX;
    end else begin
      f = item_i.frame_us;
    end
    th = (item_i.thermal_status > TH_SHUTDOWN) ? TH_SHUTDOWN : item_i.thermal_status;

    target = {f, {EMA_FRAC{1'b0}}};
    diff   = (target >= ema_q) ? (target - ema_q) : (ema_q - target);
    prod   = MUL_W'(diff) * EMA_GAIN + EMA_ROUND;
    delta  = EMA_W'(prod >> EMA_SHIFT);
    if (!seen_q) begin
      ema_d = target;
    end else if (target >= ema_q) begin
      ema_d = ema_q + delta;
    end else begin
      ema_d = ema_q - delta;
    end
    worst_d = (f > worst_q) ? f : worst_q;
  end

  // Hysteresis classification and streak counters
  always_comb begin
    f100    = PROD_W'(f) * PCT_SCALE;
    is_bad  = f100 > limits_i.budget_bad;
    is_good = f100 < limits_i.budget_good;
    dropped = DROP_W'({f, 1'b0}) > limits_i.budget_x3;
    bad1    = bad_q;
    good1   = good_q;
    if (is_bad) begin
      if (bad_q != RUN_MAX) bad1 = bad_q + RUN_BITS'(1);
      good1 = '0;
    end else if (is_good) begin
      if (good_q != RUN_MAX) good1 = good_q + RUN_BITS'(1);
      bad1 = '0;
    end
    hold1 = (hold_q != '0) ? hold_q - COUNT_W'(1) : hold_q;
  end

  // Thermal caps
  always_comb begin
    case (th) inside
      [TH_NONE:TH_LIGHT]: cap_s = limits_i.scale_max;
      TH_MODERATE: cap_s = (limits_i.scale_max > CAP_MODERATE) ? CAP_MODERATE
                                                               : limits_i.scale_max;
      TH_SEVERE:   cap_s = (limits_i.scale_max > CAP_SEVERE) ? CAP_SEVERE
                                                             : limits_i.scale_max;
      TH_CRITICAL: cap_s = (limits_i.scale_max > CAP_CRITICAL) ? CAP_CRITICAL
                                                               : limits_i.scale_max;
      default:     cap_s = (limits_i.scale_max > CAP_EMERGENCY) ? CAP_EMERGENCY
                                                                : limits_i.scale_max;
    endcase
    case (th) inside
      [TH_CRITICAL:TH_SHUTDOWN]: cap_q = '0;
      TH_SEVERE: cap_q = (limits_i.ceiling > LEVEL_W'(1)) ? LEVEL_W'(1) : limits_i.ceiling;
      default:   cap_q = limits_i.ceiling;
    endcase
  end

  // Scale first, then quality; caps and lock last
  always_comb begin
    scale_d = scale_q;
    level_d = level_q;
    bad_d   = bad1;
    good_d  = good1;
    hold_d  = hold1;
    lowered = 1'b0;
    raised  = 1'b0;
    sum_dn  = {1'b0, limits_i.scale_min} + (SCALE_W+1)'(limits_i.step);
    sum_up  = {1'b0, scale_q} + (SCALE_W+1)'(limits_i.step);

    if (item_i.lock_scale == '0 && hold1 == '0) begin
      if (CMP_W'(bad1) >= CMP_W'(limits_i.down)) begin
        if (scale_q > limits_i.scale_min) begin
          scale_d = ({1'b0, scale_q} > sum_dn) ? scale_q - SCALE_W'(limits_i.step)
                                               : limits_i.scale_min;
          lowered = 1'b1;
        end else if (level_q != '0) begin
          level_d = level_q - LEVEL_W'(1);
          lowered = 1'b1;
        end
        if (lowered) begin
          hold_d = limits_i.cooldown;
          bad_d  = '0;
        end
      end else if (CMP_W'(good1) >= CMP_W'(limits_i.up) && th < TH_MODERATE) begin
        if (scale_q < cap_s) begin
          scale_d = (sum_up > {1'b0, cap_s}) ? cap_s : sum_up[SCALE_W-1:0];
          raised  = 1'b1;
        end else if (level_q < cap_q) begin
          level_d = level_q + LEVEL_W'(1);
          raised  = 1'b1;
        end
        if (raised) begin
          hold_d = limits_i.cooldown;
          good_d = '0;
        end
      end
    end

    if (scale_d > cap_s) scale_d = cap_s;
    if (level_d > cap_q) level_d = cap_q;

    // Manual lock overrides the scale, still under the thermal cap
    fixed = (item_i.lock_scale < limits_i.scale_min) ? limits_i.scale_min
                                                     : item_i.lock_scale;
    fixed = (fixed > limits_i.scale_max) ? limits_i.scale_max : fixed;
    if (item_i.lock_scale != '0) begin
      scale_d = (fixed > cap_s) ? cap_s : fixed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= RST_MAX_SCALE;
      level_q <= LEVEL_RST;
      bad_q   <= '0;
      good_q  <= '0;
      hold_q  <= '0;
      ema_q   <= '0;
      worst_q <= '0;
      seen_q  <= 1'b0;
    end else if (fire_i) begin
      scale_q <= scale_d;
      level_q <= level_d;
      bad_q   <= bad_d;
      good_q  <= good_d;
      hold_q  <= hold_d;
      ema_q   <= ema_d;
      worst_q <= worst_d;
      seen_q  <= 1'b1;
    end
  end

  always_comb begin
    result_o.render_scale      = scale_d;
    result_o.quality_level     = level_d;
    result_o.dropped           = dropped;
    result_o.lowered           = lowered;
    result_o.raised            = raised;
    result_o.smoothed_frame_us = ema_d[EMA_W-1:EMA_FRAC];
    result_o.worst_frame_us    = worst_d;
  end

endmodule

>>> src/frame_time_quality_governor.sv
// Frame-time quality governor. Each input beat carries one frame time, the
// thermal status and an optional scale lock; each one yields exactly one
// output beat with the render scale, quality level, drop/lower/raise flags,
// the smoothed frame time and the worst frame since reset. One beat is taken
// every cycle while the output is not stalled; a result passes from the input
// register through the state update into the output register.
// The rate is set by that state update, which closes on itself each beat.
// The configuration port is always ready; a written value takes effect for
// items accepted from the cycle after the write.
module frame_time_quality_governor import ftqg_pkg::*; #(
  parameter int unsigned MAX_LEVELS = 8,
  parameter int unsigned RUN_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [19:0] frame_us, [22:20] thermal_status, [32:23] lock_scale, [39:33] ignored
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [9:0] render_scale, [12:10] quality_level, [13] dropped, [14] lowered,
  // [15] raised, [35:16] smoothed_frame_us, [55:36] worst_frame_us
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  limits_t limits;
  item_t   item_q;
  logic    in_valid_q, out_valid_q, advance;
  result_t result, res_q;

  ftqg_cfg #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .limits_o    (limits)
  );

  ftqg_core #(
    .MAX_LEVELS (MAX_LEVELS),
    .RUN_BITS   (RUN_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (item_q),
    .limits_i (limits),
    .result_o (result)
  );

  // Beat moves from input register to output register
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      item_q.frame_us       <= s_axis_tdata_i[19:0];
      item_q.thermal_status <= s_axis_tdata_i[22:20];
      item_q.lock_scale     <= s_axis_tdata_i[32:23];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {res_q.worst_frame_us, res_q.smoothed_frame_us, res_q.raised,
                            res_q.lowered, res_q.dropped, res_q.quality_level,
                            res_q.render_scale};

endmodule

>>> src/ftqg_checker.sv
module ftqg_checker import ftqg_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic [FRAME_W-1:0] last_worst_q;

  // Worst frame of the last delivered beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_worst_q <= '0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      last_worst_q <= m_axis_tdata_o[55:36];
    end
  end

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // A frame never lowers and raises at once
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[14] && m_axis_tdata_o[15]))
    else $error("lowered and raised together");

  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[9:0] <= SCALE_LIMIT)
    else $error("render scale above limit");

  // Average never exceeds the worst frame seen
  a_avg_le_worst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[35:16] <= m_axis_tdata_o[55:36])
    else $error("smoothed frame time above worst frame");

  a_worst_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[55:36] >= last_worst_q)
    else $error("worst frame decreased");

endmodule

bind frame_time_quality_governor ftqg_checker u_ftqg_checker (.*);
